FILE: design/dsa_pkg.sv
package dsa_pkg;

    // field and state widths
    localparam int TOP_W  = 17;
    localparam int SIZE_W = 16;
    localparam int ADR_W  = 16;

    // block overhead: offset word and guard below, guard word above
    localparam int HEAD_BYTES = 8;
    localparam int TAIL_BYTES = 4;

    // arena size bounds and reset value
    localparam int ARENA_MIN   = 13;
    localparam int ARENA_MAX   = 65536;
    localparam int ARENA_RESET = 1024;

    // parameter defaults
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        CMD_ALLOC_FRONT = 3'd0,
        CMD_ALLOC_BACK  = 3'd1,
        CMD_FREE_FRONT  = 3'd2,
        CMD_FREE_BACK   = 3'd3,
        CMD_RESET       = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_ZERO_SIZE = 3'd2,
        ST_RANGE     = 3'd3,
        ST_NOT_TOP   = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // one saved stack entry: top before the allocation and the block offset
    typedef struct packed {
        logic [TOP_W-1:0] prev_top;
        logic [TOP_W-1:0] addr;
    } entry_t;

endpackage

FILE: design/dsa_ram.sv
module dsa_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/double_ended_stack_allocator.sv
// Double-ended stack allocator: hands out aligned byte offsets in an arena from a front
// stack growing up from 0 and a back stack growing down from arena_size, each block
// costing 12 bytes of overhead (8 below the offset, 4 above the user bytes). Frees are
// LIFO and must name the top block of their stack; the previous tops are kept in two
// on-chip RAMs of MAX_BLOCKS entries. One request is taken per clock while the result
// channel does not stall: a beat is held in the input register and its result is then
// registered in the output register. The RAM read of the current top entry is always
// issued ahead from the counts after each edge, with a bypass for an entry written
// on the same edge. A write on cfg_we sets arena_size (clamped to 13..min(65536,
// 2^ADDR_BITS)) and empties both stacks; write it only while the block is idle.
module double_ended_stack_allocator
    import dsa_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_size[15:0], align_log2[19:16],
                                   // block_address[35:20], zero fill
    input  logic [2:0]  s_tuser,   // command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_address[15:0], front_top[32:16],
                                   // back_top[49:33], zero fill
    output logic [2:0]  m_tuser    // status
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = MAX_BLOCKS > 1 ? $clog2(MAX_BLOCKS) : 1;
    localparam int ENT_W = $bits(entry_t);
    localparam int LIM_I = ADDR_BITS >= 16 ? ARENA_MAX : (1 << ADDR_BITS);
    localparam logic [TOP_W-1:0] ARENA_LIM = TOP_W'(LIM_I);

    // input register
    logic              in_valid_reg;
    cmd_t              in_cmd_reg;
    logic [SIZE_W-1:0] in_size_reg;
    logic [3:0]        in_align_reg;
    logic [ADR_W-1:0]  in_baddr_reg;

    // allocator state
    logic [TOP_W-1:0] arena_reg;
    logic [TOP_W-1:0] front_top_reg, front_top_next;
    logic [TOP_W-1:0] back_top_reg, back_top_next;
    logic [CNT_W-1:0] front_cnt_reg, front_cnt_next;
    logic [CNT_W-1:0] back_cnt_reg, back_cnt_next;

    // top entry bypass
    logic             f_byp_reg, b_byp_reg;
    entry_t           f_byp_data_reg, b_byp_data_reg;
    logic [ENT_W-1:0] f_rdata, b_rdata;
    entry_t           f_top_ent, b_top_ent;

    // output register
    logic             out_valid_reg;
    logic [ADR_W-1:0] out_addr_reg;
    status_t          out_status_reg;
    logic [TOP_W-1:0] out_ftop_reg, out_btop_reg;

    logic             proc;
    logic             f_push, b_push;
    entry_t           f_wr_ent, b_wr_ent;
    status_t          status_next;
    logic [ADR_W-1:0] result_next;
    logic [TOP_W-1:0] arena_clamped;

    // front fit
    logic [TOP_W:0]   f_align, f_base, f_addr;
    logic [TOP_W+1:0] f_end;
    // back fit
    logic [TOP_W-1:0] b_align, b_need, b_addr;
    logic             b_short, b_clash;

    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    assign f_top_ent = f_byp_reg ? f_byp_data_reg : entry_t'(f_rdata);
    assign b_top_ent = b_byp_reg ? b_byp_data_reg : entry_t'(b_rdata);

    // clamp of a configuration write
    always_comb begin
        if (cfg_wdata < TOP_W'(ARENA_MIN)) begin
            arena_clamped = TOP_W'(ARENA_MIN);
        end else if (cfg_wdata > ARENA_LIM) begin
            arena_clamped = ARENA_LIM;
        end else begin
            arena_clamped = cfg_wdata;
        end
    end

    // fit arithmetic for both stacks
    always_comb begin
        f_align = (TOP_W+1)'(1) << in_align_reg;
        f_base  = {1'b0, front_top_reg} + (TOP_W+1)'(HEAD_BYTES) + (f_align - 1'b1);
        f_addr  = f_base & ~(f_align - 1'b1);
        f_end   = {1'b0, f_addr} + (TOP_W+2)'(in_size_reg) + (TOP_W+2)'(TAIL_BYTES);

        b_align = TOP_W'(1) << in_align_reg;
        b_need  = TOP_W'(in_size_reg) + TOP_W'(TAIL_BYTES);
        b_short = back_top_reg < b_need;
        b_addr  = (back_top_reg - b_need) & ~(b_align - 1'b1);
        b_clash = {1'b0, b_addr} < ({1'b0, front_top_reg} + (TOP_W+1)'(HEAD_BYTES));
    end

    // command decode and next state
    always_comb begin
        front_top_next = front_top_reg;
        back_top_next  = back_top_reg;
        front_cnt_next = front_cnt_reg;
        back_cnt_next  = back_cnt_reg;
        status_next    = ST_OK;
        result_next    = '0;
        f_push         = 1'b0;
        b_push         = 1'b0;
        f_wr_ent       = '{prev_top: front_top_reg, addr: f_addr[TOP_W-1:0]};
        b_wr_ent       = '{prev_top: back_top_reg, addr: b_addr};

        case (in_cmd_reg)
            CMD_ALLOC_FRONT: begin
                if (in_size_reg == '0) begin
                    status_next = ST_ZERO_SIZE;
                end else if (front_cnt_reg >= CNT_W'(MAX_BLOCKS)) begin
                    status_next = ST_FULL;
                end else if (f_end > {2'b00, back_top_reg}) begin
                    status_next = ST_NO_SPACE;
                end else begin
                    f_push         = 1'b1;
                    front_cnt_next = front_cnt_reg + 1'b1;
                    front_top_next = f_end[TOP_W-1:0];
                    result_next    = f_addr[ADR_W-1:0];
                end
            end
            CMD_ALLOC_BACK: begin
                if (in_size_reg == '0) begin
                    status_next = ST_ZERO_SIZE;
                end else if (back_cnt_reg >= CNT_W'(MAX_BLOCKS)) begin
                    status_next = ST_FULL;
                end else if (b_short || b_clash) begin
                    status_next = ST_NO_SPACE;
                end else begin
                    b_push        = 1'b1;
                    back_cnt_next = back_cnt_reg + 1'b1;
                    back_top_next = b_addr - TOP_W'(HEAD_BYTES);
                    result_next   = b_addr[ADR_W-1:0];
                end
            end
            CMD_FREE_FRONT: begin
                if (in_baddr_reg == '0) begin
                    status_next = ST_OK;
                end else if ({1'b0, in_baddr_reg} >= arena_reg) begin
                    status_next = ST_RANGE;
                end else if (front_cnt_reg == '0
                             || f_top_ent.addr != {1'b0, in_baddr_reg}) begin
                    status_next = ST_NOT_TOP;
                end else begin
                    front_cnt_next = front_cnt_reg - 1'b1;
                    front_top_next = f_top_ent.prev_top;
                end
            end
            CMD_FREE_BACK: begin
                if (in_baddr_reg == '0) begin
                    status_next = ST_OK;
                end else if ({1'b0, in_baddr_reg} >= arena_reg) begin
                    status_next = ST_RANGE;
                end else if (back_cnt_reg == '0
                             || b_top_ent.addr != {1'b0, in_baddr_reg}) begin
                    status_next = ST_NOT_TOP;
                end else begin
                    back_cnt_next = back_cnt_reg - 1'b1;
                    back_top_next = b_top_ent.prev_top;
                end
            end
            CMD_RESET: begin
                front_top_next = '0;
                back_top_next  = arena_reg;
                front_cnt_next = '0;
                back_cnt_next  = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // counts as they stand after this edge, for the read-ahead address
    logic [CNT_W-1:0] f_cnt_after, b_cnt_after;
    logic [CNT_W-1:0] f_rd_cnt, b_rd_cnt;

    always_comb begin
        if (cfg_we) begin
            f_cnt_after = '0;
            b_cnt_after = '0;
        end else if (proc) begin
            f_cnt_after = front_cnt_next;
            b_cnt_after = back_cnt_next;
        end else begin
            f_cnt_after = front_cnt_reg;
            b_cnt_after = back_cnt_reg;
        end
        f_rd_cnt = f_cnt_after - 1'b1;
        b_rd_cnt = b_cnt_after - 1'b1;
    end

    // saved tops
    dsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_front_ram (
        .aclk    (aclk),
        .wr_en   (proc && f_push),
        .wr_addr (front_cnt_reg[IDX_W-1:0]),
        .wr_data (f_wr_ent),
        .rd_addr (f_rd_cnt[IDX_W-1:0]),
        .rd_data (f_rdata)
    );

    dsa_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_back_ram (
        .aclk    (aclk),
        .wr_en   (proc && b_push),
        .wr_addr (back_cnt_reg[IDX_W-1:0]),
        .wr_data (b_wr_ent),
        .rd_addr (b_rd_cnt[IDX_W-1:0]),
        .rd_data (b_rdata)
    );

    // bypass of an entry written on the edge that reads it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_byp_reg <= 1'b0;
            b_byp_reg <= 1'b0;
        end else begin
            f_byp_reg <= proc && f_push && !cfg_we;
            b_byp_reg <= proc && b_push && !cfg_we;
        end
        f_byp_data_reg <= f_wr_ent;
        b_byp_data_reg <= b_wr_ent;
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_size_reg  <= s_tdata[15:0];
            in_align_reg <= s_tdata[19:16];
            in_baddr_reg <= s_tdata[35:20];
        end
    end

    // allocator state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg     <= TOP_W'(ARENA_RESET);
            front_top_reg <= '0;
            back_top_reg  <= TOP_W'(ARENA_RESET);
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
        end else if (cfg_we) begin
            arena_reg     <= arena_clamped;
            front_top_reg <= '0;
            back_top_reg  <= arena_clamped;
            front_cnt_reg <= '0;
            back_cnt_reg  <= '0;
        end else if (proc) begin
            front_top_reg <= front_top_next;
            back_top_reg  <= back_top_next;
            front_cnt_reg <= front_cnt_next;
            back_cnt_reg  <= back_cnt_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc) begin
            out_addr_reg   <= result_next;
            out_status_reg <= status_next;
            out_ftop_reg   <= front_top_next;
            out_btop_reg   <= back_top_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b0, out_btop_reg, out_ftop_reg, out_addr_reg};

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_cnt_reg <= CNT_W'(MAX_BLOCKS) && back_cnt_reg <= CNT_W'(MAX_BLOCKS))
        else $error("stack count above capacity");

    a_tops_order: assert property (@(posedge aclk) disable iff (!aresetn)
        front_top_reg <= back_top_reg)
        else $error("front stack crossed back stack");

    a_back_in_arena: assert property (@(posedge aclk) disable iff (!aresetn)
        back_top_reg <= arena_reg)
        else $error("back top beyond arena");

    a_fail_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !cfg_we && status_next != ST_OK
        |=> $stable(front_top_reg) && $stable(back_top_reg)
            && $stable(front_cnt_reg) && $stable(back_cnt_reg))
        else $error("failed request changed allocator state");

    a_ok_alloc_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && (f_push || b_push) |-> result_next != '0 && status_next == ST_OK)
        else $error("successful allocation with null offset");

endmodule

FILE: dv/tb_double_ended_stack_allocator.sv
module tb_double_ended_stack_allocator;
    import dsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // unused command codes, expected to do nothing
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int MAX_BLOCKS  = MAX_BLOCKS_DEF;
    localparam int ARENA_LIMIT = (ARENA_MAX < (1 << ADDR_BITS_DEF)) ? ARENA_MAX
                                                                   : (1 << ADDR_BITS_DEF);
    localparam int PHASES       = 11;
    localparam int DRAIN_CYCLES = 4;

    // a free may name the live top block, the one under it, or a given offset
    typedef enum logic [1:0] {
        AIM_NONE,
        AIM_TOP,
        AIM_BELOW
    } aim_t;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] size;
        logic [3:0]  align;
        logic [15:0] baddr;
        aim_t        aim;
    } request_t;

    typedef struct packed {
        logic [15:0] addr;
        status_t     status;
        logic [16:0] ftop;
        logic [16:0] btop;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // request_size[15:0], align_log2[19:16],
                                 // block_address[35:20], zero fill
    logic [2:0]  s_tuser = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // result_address[15:0], front_top[32:16],
                                 // back_top[49:33], zero fill
    logic [2:0]  m_tuser;        // status

    double_ended_stack_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // allocator state as predicted from the accepted beats
    logic [16:0] arena_bytes;
    logic [16:0] front_top;
    logic [16:0] back_top;
    int          front_cnt;
    int          back_cnt;
    entry_t      front_stk [MAX_BLOCKS];
    entry_t      back_stk [MAX_BLOCKS];

    request_t    request_q [$];
    outcome_t    outcome_q [$];
    int          err_count = 0;
    int          req_beats = 0;
    int          rsp_beats = 0;
    bit          req_taken = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_stacks();
        front_top = '0;
        back_top  = arena_bytes;
        front_cnt = 0;
        back_cnt  = 0;
    endfunction

    // free of the top block on one side, lifo order only
    function automatic status_t pop_block(bit back_side, logic [15:0] addr);
        int     cnt;
        entry_t head;
        cnt = back_side ? back_cnt : front_cnt;
        if (addr == 0) return ST_OK;
        if (addr >= arena_bytes) return ST_RANGE;
        if (cnt == 0) return ST_NOT_TOP;
        head = back_side ? back_stk[cnt-1] : front_stk[cnt-1];
        if (head.addr != addr) return ST_NOT_TOP;
        if (back_side) begin
            back_cnt--;
            back_top = head.prev_top;
        end else begin
            front_cnt--;
            front_top = head.prev_top;
        end
        return ST_OK;
    endfunction

    // expected result of one request, updating the predicted state
    function automatic outcome_t allocator_outcome(request_t r);
        outcome_t    o;
        entry_t      ent;
        logic [31:0] step, mask, a, tail_end, need;
        o.addr   = '0;
        o.status = ST_OK;
        step = 32'd1 << r.align;
        mask = ~(step - 32'd1);
        case (r.cmd)
            CMD_ALLOC_FRONT: begin
                a        = (front_top + HEAD_BYTES + step - 32'd1) & mask;
                tail_end = a + r.size + TAIL_BYTES;
                if (r.size == 0) begin
                    o.status = ST_ZERO_SIZE;
                end else if (front_cnt >= MAX_BLOCKS) begin
                    o.status = ST_FULL;
                end else if (tail_end > back_top) begin
                    o.status = ST_NO_SPACE;
                end else begin
                    ent.prev_top = front_top;
                    ent.addr     = a[16:0];
                    front_stk[front_cnt] = ent;
                    front_cnt++;
                    front_top = tail_end[16:0];
                    o.addr    = a[15:0];
                end
            end
            CMD_ALLOC_BACK: begin
                need = r.size + TAIL_BYTES;
                if (r.size == 0) begin
                    o.status = ST_ZERO_SIZE;
                end else if (back_cnt >= MAX_BLOCKS) begin
                    o.status = ST_FULL;
                end else if (back_top < need) begin
                    o.status = ST_NO_SPACE;
                end else begin
                    a = (back_top - need) & mask;
                    if (a < front_top + HEAD_BYTES) begin
                        o.status = ST_NO_SPACE;
                    end else begin
                        ent.prev_top = back_top;
                        ent.addr     = a[16:0];
                        back_stk[back_cnt] = ent;
                        back_cnt++;
                        back_top = a[16:0] - 17'(HEAD_BYTES);
                        o.addr   = a[15:0];
                    end
                end
            end
            CMD_FREE_FRONT: o.status = pop_block(1'b0, r.baddr);
            CMD_FREE_BACK:  o.status = pop_block(1'b1, r.baddr);
            CMD_RESET:      clear_stacks();
            default: ;
        endcase
        o.ftop = front_top;
        o.btop = back_top;
        return o;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic void add_req(logic [2:0] cmd, logic [15:0] size, logic [3:0] align,
                                    logic [15:0] baddr, aim_t aim);
        request_t r;
        r.cmd   = cmd;
        r.size  = size;
        r.align = align;
        r.baddr = baddr;
        r.aim   = aim;
        request_q.push_back(r);
    endfunction

    // fill phases push hard toward full stacks, mixed phases exercise every path
    function automatic request_t random_request(bit fill);
        request_t r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)       r.size = '0;
        else if (pick < 12) r.size = 16'($urandom_range(0, 65535));
        else if (fill)      r.size = 16'($urandom_range(1, 8));
        else                r.size = 16'($urandom_range(1, 64));
        if ($urandom_range(0, 9) == 0) r.align = 4'($urandom_range(0, 15));
        else                           r.align = 4'($urandom_range(0, fill ? 2 : 4));
        r.baddr = 16'($urandom_range(0, 65535));
        r.aim   = AIM_NONE;
        pick = $urandom_range(0, 99);
        if (fill) begin
            if (pick < 46)      r.cmd = CMD_ALLOC_FRONT;
            else if (pick < 92) r.cmd = CMD_ALLOC_BACK;
            else begin
                r.cmd = (pick < 96) ? CMD_FREE_FRONT : CMD_FREE_BACK;
                r.aim = AIM_TOP;
            end
        end else begin
            if (pick < 30) begin
                r.cmd = CMD_ALLOC_FRONT;
            end else if (pick < 55) begin
                r.cmd = CMD_ALLOC_BACK;
            end else if (pick < 80) begin
                r.cmd = (pick < 68) ? CMD_FREE_FRONT : CMD_FREE_BACK;
                r.aim = AIM_TOP;
            end else if (pick < 84) begin
                r.cmd = (pick < 82) ? CMD_FREE_FRONT : CMD_FREE_BACK;
                r.aim = AIM_BELOW;
            end else if (pick < 90) begin
                // stray frees: null, plausible offset or anything
                r.cmd = $urandom_range(0, 1) ? CMD_FREE_FRONT : CMD_FREE_BACK;
                if (pick < 86)      r.baddr = '0;
                else if (pick < 88) r.baddr = 16'($urandom_range(1, 1023));
            end else if (pick < 92) begin
                r.cmd = CMD_RESET;
            end else if (pick < 95) begin
                r.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end else begin
                r.cmd  = $urandom_range(0, 1) ? CMD_ALLOC_FRONT : CMD_ALLOC_BACK;
                r.size = 16'($urandom_range(0, 65535));
            end
        end
        return r;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        err_count++;
    endtask

    // prediction on input beats, checking on output beats, config tracking
    always @(posedge aclk) begin : track_and_check
        request_t r;
        outcome_t want;
        req_taken = 1'b0;
        if (!aresetn) begin
            arena_bytes = 17'(ARENA_RESET);
            clear_stacks();
        end else begin
            if (cfg_we) begin
                if (cfg_wdata < ARENA_MIN)        arena_bytes = 17'(ARENA_MIN);
                else if (cfg_wdata > ARENA_LIMIT) arena_bytes = 17'(ARENA_LIMIT);
                else                              arena_bytes = cfg_wdata;
                clear_stacks();
            end
            if (m_tvalid && m_tready) begin
                rsp_beats++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %0h status %0h",
                             $time, m_tdata, m_tuser);
                    err_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_tdata[15:0] != want.addr)
                        report("result_address", want.addr, m_tdata[15:0]);
                    if (m_tuser != want.status)
                        report("status", want.status, m_tuser);
                    if (m_tdata[32:16] != want.ftop)
                        report("front_top", want.ftop, m_tdata[32:16]);
                    if (m_tdata[49:33] != want.btop)
                        report("back_top", want.btop, m_tdata[49:33]);
                end
            end
            if (s_tvalid && s_tready) begin
                req_taken = 1'b1;
                req_beats++;
                r.cmd   = s_tuser;
                r.size  = s_tdata[15:0];
                r.align = s_tdata[19:16];
                r.baddr = s_tdata[35:20];
                r.aim   = AIM_NONE;
                outcome_q.push_back(allocator_outcome(r));
            end
        end
    end

    // request driver with random gaps and calm stretches
    int send_gap = 0;

    always @(negedge aclk) begin : drive_requests
        request_t r;
        int       cnt;
        int       depth;
        bit       back_side;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap--;
            end else if (request_q.size() != 0) begin
                r = request_q.pop_front();
                // frees aimed at a live block pick its offset from the current state
                if (r.aim != AIM_NONE) begin
                    back_side = (r.cmd == CMD_FREE_BACK);
                    cnt   = back_side ? back_cnt : front_cnt;
                    depth = (r.aim == AIM_TOP) ? 1 : 2;
                    if (cnt >= depth)
                        r.baddr = back_side ? back_stk[cnt-depth].addr[15:0]
                                            : front_stk[cnt-depth].addr[15:0];
                end
                s_tdata  <= {4'b0, r.baddr, r.align, r.size};
                s_tuser  <= r.cmd;
                s_tvalid <= 1'b1;
                send_gap = ((req_beats / 100) % 4 == 3) ? 0 : idle_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus two long hold-offs
    int ready_gap  = 0;
    int hold_left  = 0;
    int hold_marks = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_marks < 2 && req_beats >= (hold_marks == 0 ? 300 : 1200)) begin
            m_tready <= 1'b0;
            hold_left = 79;
            hold_marks++;
        end else if (ready_gap > 0) begin
            m_tready <= 1'b0;
            ready_gap--;
        end else begin
            m_tready <= 1'b1;
            ready_gap = ((rsp_beats / 100) % 4 == 1) ? 0 : idle_gap();
        end
    end

    task automatic wait_drained();
        do @(negedge aclk);
        while (request_q.size() != 0 || s_tvalid || outcome_q.size() != 0);
    endtask

    // stimulus phases
    initial begin : stimulus
        logic [16:0] arena_val;
        bit          fill;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed checks on the reset arena of 1024 bytes
        add_req(CMD_ALLOC_FRONT, 16'd0, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_BACK, 16'd0, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_FRONT, 16'd1, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_FRONT, 16'd16, 4'd4, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_BACK, 16'd100, 4'd3, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_BACK, 16'd1, 4'd15, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_FRONT, 16'hFFFF, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_BACK, 16'hFFFF, 4'd15, 16'd0, AIM_NONE);
        add_req(CMD_ALLOC_FRONT, 16'd1, 4'd15, 16'd0, AIM_NONE);
        // null free ignores the other fields
        add_req(CMD_FREE_FRONT, 16'hFFFF, 4'd15, 16'd0, AIM_NONE);
        add_req(CMD_FREE_FRONT, 16'd0, 4'd0, 16'd1024, AIM_NONE);
        add_req(CMD_FREE_BACK, 16'd0, 4'd0, 16'hFFFF, AIM_NONE);
        add_req(CMD_FREE_FRONT, 16'd0, 4'd0, 16'd8, AIM_NONE);
        add_req(CMD_FREE_FRONT, 16'd0, 4'd0, 16'd0, AIM_TOP);
        add_req(CMD_FREE_FRONT, 16'd0, 4'd0, 16'd0, AIM_TOP);
        // free on an empty stack
        add_req(CMD_FREE_FRONT, 16'd0, 4'd0, 16'd8, AIM_NONE);
        add_req(CMD_FREE_BACK, 16'd0, 4'd0, 16'd4, AIM_NONE);
        add_req(CMD_FREE_BACK, 16'd0, 4'd0, 16'd0, AIM_TOP);
        add_req(CMD_FREE_BACK, 16'd0, 4'd0, 16'd920, AIM_NONE);
        add_req(CMD_ALLOC_BACK, 16'd8, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_RESET, 16'd0, 4'd0, 16'd0, AIM_NONE);
        add_req(CMD_FREE_BACK, 16'd0, 4'd0, 16'd1012, AIM_NONE);
        add_req(CMD_SPARE_FIRST, 16'h5A5A, 4'd5, 16'hA5A5, AIM_NONE);
        add_req(CMD_SPARE_MID, 16'h1234, 4'd9, 16'h4321, AIM_NONE);
        add_req(CMD_SPARE_LAST, 16'hFFFF, 4'd15, 16'hFFFF, AIM_NONE);

        // random phases over several arena sizes, extremes first
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       arena_val = 17'h1FFFF;
                1:       arena_val = 17'd0;
                2:       arena_val = 17'd65536;
                3:       arena_val = 17'd13;
                4:       arena_val = 17'd12;
                8:       arena_val = 17'($urandom_range(0, 131071));
                default: arena_val = 17'($urandom_range(14, 4096));
            endcase
            fill = (ph == 0 || ph == 2);
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_wdata <= arena_val;
            @(negedge aclk);
            cfg_we <= 1'b0;
            @(posedge aclk);
            repeat (fill ? 200 : 140) request_q.push_back(random_request(fill));
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
